// ===== rtl/fvh_pkg.sv =====
`default_nettype none
package fvh_pkg;
   localparam int MAX_BINS = 64;
   localparam int COUNT_BITS = 24;
   localparam int BIN_BITS = $clog2(MAX_BINS);
   localparam int CSR_IDX_BITS = 2;

   typedef enum logic [2:0] {
      QSEL_PT = 3'd0, QSEL_PX = 3'd1, QSEL_PY = 3'd2, QSEL_PZ = 3'd3,
      QSEL_EN = 3'd4, QSEL_MASS = 3'd5
   } qsel_type;

   localparam logic [CSR_IDX_BITS-1:0] CSR_QSEL = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BINS = 2'd3;

   typedef struct packed {
      logic action;
      logic signed [31:0] mom_x;
      logic signed [31:0] mom_y;
      logic signed [31:0] mom_z;
      logic signed [31:0] energy_in;
   } req_type;

   typedef struct packed {
      logic [5:0] bin_index;
      logic signed [31:0] bin_start;
      logic [16:0] probability;
      logic last_bin;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/four_vector_histogram_unit.sv =====
// channel | ports                          | direction
// request | req_start, req_busy, req_data  | in, start while not busy
// result  | rsp_valid, rsp_data            | out, one cycle each
// config  | csr_we, csr_index, csr_wdata   | in, plain write
// accumulate: for a single component the range check, the bin division and the count
//   update; for pt and mass first the squared terms (two for pt, four for mass) and
//   the root; a value outside the range ends after the range check,
//   a negative mass argument after the squares
// read-out: per bin a read state, two serial divisions (start edge, then probability)
//   and an emit state, then a pass over all bins that clears the counts; an empty
//   range goes straight to the clear pass
// reset enters the clear pass that zeroes the counts; results cannot be stalled
`default_nettype none
module four_vector_histogram_unit (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_start,
   output logic req_busy,
   input  wire fvh_pkg::req_type req_data,
   output logic rsp_valid,
   output fvh_pkg::rsp_type rsp_data,
   input  wire logic csr_we,
   input  wire logic [fvh_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [31:0] csr_wdata
);
   import fvh_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_SQ    = 11'b00000000010,
      S_SQRT  = 11'b00000000100,
      S_RANGE = 11'b00000001000,
      S_DIV   = 11'b00000010000,
      S_INC   = 11'b00000100000,
      S_EDGE  = 11'b00001000000,
      S_PROB  = 11'b00010000000,
      S_EMIT  = 11'b00100000000,
      S_CLEAR = 11'b01000000000,
      S_RD    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [2:0] qsel_ff;
   logic signed [31:0] rmin_ff, rmax_ff;
   logic [6:0] bins_ff;

   logic [COUNT_BITS-1:0] mem [MAX_BINS];
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] rd_ff;

   // operands and serial squarer
   logic [31:0] mag_ff [4];
   logic [31:0] mag_in [4];
   logic [31:0] mq_ff, mq_in;      // multiplier bits shifting out
   logic [63:0] mc_ff, mc_in;      // multiplicand shifting up
   logic [65:0] acc_ff, acc_in;    // sum of squares (signed difference for mass)
   logic [1:0]  op_ff, op_in;
   logic [5:0]  cnt_ff, cnt_in;

   // restoring sqrt / divider share a remainder
   logic [65:0] rad_ff, rad_in;
   logic [33:0] root_ff, root_in;
   logic [35:0] rem_ff, rem_in;
   logic [40:0] num_ff, num_in;    // dividend shifted out msb first
   logic [40:0] quo_ff, quo_in;
   logic [33:0] den_ff, den_in;

   logic signed [33:0] val_ff, val_in;
   logic [BIN_BITS-1:0] bin_ff, bin_in;
   logic [6:0] k_ff, k_in;
   logic signed [31:0] start_ff, start_in;
   logic out_v_ff, out_v_in;
   rsp_type out_ff, out_in;

   logic [6:0] n_eff;
   logic signed [32:0] width_w;
   logic [35:0] trial;
   logic [35:0] sq_trial;

   always_comb begin
      n_eff = bins_ff;
      if (bins_ff == 7'd0) n_eff = 7'd1;
      if (bins_ff > 7'(MAX_BINS)) n_eff = 7'(MAX_BINS);
      width_w = 33'(rmax_ff) - 33'(rmin_ff);
   end

   assign req_busy = (state_ff != S_IDLE);
   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;

   function automatic logic [31:0] absv(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? 32'(-v) : 32'(v);
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      for (int i = 0; i < 4; i++) mag_in[i] = mag_ff[i];
      mq_in = mq_ff; mc_in = mc_ff; acc_in = acc_ff; op_in = op_ff;
      cnt_in = cnt_ff; rad_in = rad_ff; root_in = root_ff; rem_in = rem_ff;
      num_in = num_ff; quo_in = quo_ff; den_in = den_ff; val_in = val_ff;
      bin_in = bin_ff; k_in = k_ff; start_in = start_ff; total_in = total_ff;
      out_v_in = 1'b0; out_in = out_ff;
      trial = '0; sq_trial = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_start) begin
               k_in = '0;
               if (req_data.action) begin
                  state_in = (width_w > 0) ? S_RD : S_CLEAR;
                  bin_in = '0;
               end else begin
                  mag_in[0] = absv(req_data.mom_x);
                  mag_in[1] = absv(req_data.mom_y);
                  mag_in[2] = absv(req_data.mom_z);
                  mag_in[3] = absv(req_data.energy_in);
                  acc_in = '0;
                  case (qsel_ff)
                     QSEL_PT, QSEL_MASS: begin
                        op_in = 2'd0; cnt_in = '0;
                        mq_in = absv(req_data.mom_x);
                        mc_in = 64'(absv(req_data.mom_x));
                        state_in = S_SQ;
                     end
                     QSEL_PX: begin val_in = 34'(req_data.mom_x); state_in = S_RANGE; end
                     QSEL_PY: begin val_in = 34'(req_data.mom_y); state_in = S_RANGE; end
                     QSEL_PZ: begin val_in = 34'(req_data.mom_z); state_in = S_RANGE; end
                     QSEL_EN: begin
                        val_in = 34'(req_data.energy_in); state_in = S_RANGE;
                     end
                     default: state_in = S_IDLE;
                  endcase
               end
            end
         end
         S_SQ: begin
            // one multiplier bit per cycle; for mass the energy term is added, momenta subtracted
            if (mq_ff[0]) begin
               if (qsel_ff == QSEL_MASS && op_ff != 2'd3) acc_in = acc_ff - 66'(mc_ff);
               else acc_in = acc_ff + 66'(mc_ff);
            end
            mq_in = mq_ff >> 1;
            mc_in = mc_ff << 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               cnt_in = '0;
               if ((qsel_ff == QSEL_PT && op_ff == 2'd1) || op_ff == 2'd3) begin
                  rad_in = acc_in; root_in = '0; rem_in = '0;
                  if (acc_in[65]) state_in = S_IDLE;
                  else state_in = S_SQRT;
               end else begin
                  op_in = (qsel_ff == QSEL_PT) ? 2'd1 : op_ff + 2'd1;
                  mq_in = mag_ff[op_in];
                  mc_in = 64'(mag_ff[op_in]);
               end
            end
         end
         S_SQRT: begin
            // two radicand bits per cycle, one root bit
            sq_trial = {rem_ff[33:0], rad_ff[65:64]} - {root_ff, 2'b01};
            if (!sq_trial[35]) begin
               rem_in = sq_trial;
               root_in = {root_ff[32:0], 1'b1};
            end else begin
               rem_in = {rem_ff[33:0], rad_ff[65:64]};
               root_in = {root_ff[32:0], 1'b0};
            end
            rad_in = rad_ff << 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd32) begin
               cnt_in = '0;
               val_in = 34'(root_in[32:0]);
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            if (width_w <= 0 || val_ff < 34'(rmin_ff) || val_ff >= 34'(rmax_ff))
               state_in = S_IDLE;
            else begin
               // (v - min) * n, at most 33+7 bits
               num_in = 41'(34'(val_ff - 34'(rmin_ff)) * n_eff);
               den_in = 34'(width_w);
               rem_in = '0; quo_in = '0; cnt_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV, S_EDGE, S_PROB: begin
            trial = {rem_ff[34:0], num_ff[40]} - 36'(den_ff);
            if (!trial[35]) begin
               rem_in = trial; quo_in = {quo_ff[39:0], 1'b1};
            end else begin
               rem_in = {rem_ff[34:0], num_ff[40]}; quo_in = {quo_ff[39:0], 1'b0};
            end
            num_in = num_ff << 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd40) begin
               cnt_in = '0;
               case (state_ff)
                  S_DIV: begin
                     bin_in = BIN_BITS'(quo_in);
                     state_in = S_INC;
                  end
                  S_EDGE: begin
                     start_in = 32'(33'(rmin_ff) + 33'(quo_in));
                     num_in = 41'({rd_ff, 16'h0000});
                     den_in = 34'(total_ff);
                     rem_in = '0; quo_in = '0;
                     state_in = S_PROB;
                  end
                  default: begin
                     out_v_in = 1'b1;
                     out_in.bin_index = 6'(k_ff);
                     out_in.bin_start = start_ff;
                     out_in.probability = (total_ff == '0) ? 17'd0 :
                        (quo_in > 41'd65536) ? 17'd65536 : 17'(quo_in);
                     out_in.last_bin = (k_ff == n_eff - 7'd1);
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_INC: begin
            if (total_ff != '1) total_in = total_ff + 1'b1;
            state_in = S_IDLE;
         end
         S_RD: begin
            // read count, then the edge divide: k*W/n
            bin_in = BIN_BITS'(k_ff);
            num_in = 41'(k_ff * 33'(width_w));
            den_in = 34'(n_eff);
            rem_in = '0; quo_in = '0; cnt_in = '0;
            state_in = S_EDGE;
         end
         S_EMIT: begin
            k_in = k_ff + 7'd1;
            if (k_in == n_eff) begin
               bin_in = '0; state_in = S_CLEAR;
            end else begin
               state_in = S_RD;
            end
         end
         S_CLEAR: begin
            bin_in = bin_ff + 1'b1;
            total_in = '0;
            if (bin_ff == BIN_BITS'(MAX_BINS - 1)) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         bin_ff <= '0;
         total_ff <= '0;
         out_v_ff <= 1'b0;
         qsel_ff <= '0;
         rmin_ff <= '0;
         rmax_ff <= 32'sd25600;
         bins_ff <= 7'd64;
      end else begin
         state_ff <= state_in;
         bin_ff <= bin_in;
         total_ff <= total_in;
         out_v_ff <= out_v_in;
         if (csr_we) begin
            case (csr_index)
               CSR_QSEL: qsel_ff <= csr_wdata[2:0];
               CSR_MIN:  rmin_ff <= csr_wdata;
               CSR_MAX:  rmax_ff <= csr_wdata;
               CSR_BINS: bins_ff <= csr_wdata[6:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) mag_ff[i] <= mag_in[i];
      mq_ff <= mq_in; mc_ff <= mc_in; acc_ff <= acc_in; op_ff <= op_in;
      cnt_ff <= cnt_in; rad_ff <= rad_in; root_ff <= root_in; rem_ff <= rem_in;
      num_ff <= num_in; quo_ff <= quo_in; den_ff <= den_in; val_ff <= val_in;
      k_ff <= k_in; start_ff <= start_in; out_ff <= out_in;
   end

   // count memory: registered read, read-modify-write in S_INC, swept in S_CLEAR
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) mem[bin_ff] <= '0;
      else if (state_ff == S_INC && rd_ff != '1) mem[bin_ff] <= rd_ff + 1'b1;
      rd_ff <= mem[bin_in];
   end

`ifndef SYNTHESIS
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_busy) else $error("result outside a read-out");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back to back results");
   a_clear_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |=> (total_ff == '0)) else $error("total not cleared");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import fvh_pkg::*;

   localparam int SETTLE_CYCLES = 300;

   logic clock;
   logic reset;
   logic req_start;
   logic req_busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [31:0] csr_wdata;

   four_vector_histogram_unit dut (
      .clock(clock), .reset(reset),
      .req_start(req_start), .req_busy(req_busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow copy of the histogram state and its settings
   logic [2:0] cfg_qsel;
   logic signed [31:0] cfg_min;
   logic signed [31:0] cfg_max;
   logic [6:0] cfg_bins;
   logic [COUNT_BITS-1:0] hist_counts [MAX_BINS];
   logic [COUNT_BITS-1:0] hist_total;

   rsp_type expected_bins [$];
   int mismatches;
   int events_sent;
   int readouts_sent;
   int bins_checked;
   bit pace_off;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("** four_vector_histogram_unit: FAILED **");
      $finish;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v && trial <= 64'hFFFF_FFFF) root = trial;
      end
      return root;
   endfunction

   function automatic longint unsigned square_mag(logic signed [31:0] c);
      longint m;
      m = c;
      if (m < 0) m = -m;
      return longint'(m) * longint'(m);
   endfunction

   function automatic longint active_bins();
      if (cfg_bins == 0) return 1;
      if (cfg_bins > MAX_BINS) return MAX_BINS;
      return cfg_bins;
   endfunction

   task automatic clear_histogram();
      foreach (hist_counts[i]) hist_counts[i] = '0;
      hist_total = '0;
   endtask

   task automatic bin_event(req_type it);
      longint v;
      longint w;
      longint n;
      longint k;
      longint unsigned p2;
      longint unsigned e2;
      w = longint'(cfg_max) - longint'(cfg_min);
      n = active_bins();
      case (cfg_qsel)
         QSEL_PT: v = int_sqrt(square_mag(it.mom_x) + square_mag(it.mom_y));
         QSEL_PX: v = it.mom_x;
         QSEL_PY: v = it.mom_y;
         QSEL_PZ: v = it.mom_z;
         QSEL_EN: v = it.energy_in;
         QSEL_MASS: begin
            p2 = square_mag(it.mom_x) + square_mag(it.mom_y) + square_mag(it.mom_z);
            e2 = square_mag(it.energy_in);
            if (e2 < p2) return;
            v = int_sqrt(e2 - p2);
         end
         default: return;
      endcase
      if (w <= 0 || v < cfg_min || v >= cfg_max) return;
      k = ((v - cfg_min) * n) / w;
      if (k < 0 || k >= n) return;
      if (hist_counts[k] != '1) hist_counts[k]++;
      if (hist_total != '1) hist_total++;
   endtask

   task automatic emit_histogram();
      longint w;
      longint n;
      longint unsigned prob;
      rsp_type r;
      w = longint'(cfg_max) - longint'(cfg_min);
      n = active_bins();
      if (w > 0) begin
         for (longint k = 0; k < n; k++) begin
            prob = 0;
            if (hist_total != 0)
               prob = (longint'(hist_counts[k]) << 16) / longint'(hist_total);
            if (prob > 65536) prob = 65536;
            r.bin_index = k[5:0];
            r.bin_start = 32'(longint'(cfg_min) + (k * w) / n);
            r.probability = prob[16:0];
            r.last_bin = (k == n - 1);
            expected_bins = {expected_bins, r};
         end
      end
      clear_histogram();
   endtask

   task automatic send_item(req_type it);
      req_start <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_busy) @(posedge clock);
      if (it.action) begin
         readouts_sent++;
         emit_histogram();
      end else begin
         events_sent++;
         bin_event(it);
      end
      if (!pace_off && $urandom_range(0, 99) < 26) begin
         req_start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic send_event(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] e);
      req_type it;
      it.action = 1'b0;
      it.mom_x = x;
      it.mom_y = y;
      it.mom_z = z;
      it.energy_in = e;
      send_item(it);
   endtask

   task automatic send_readout();
      req_type it;
      it = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
      it.action = 1'b1;
      send_item(it);
   endtask

   task automatic wait_idle();
      req_start <= 1'b0;
      @(posedge clock);
      while (expected_bins.size() != 0 || req_busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_QSEL: cfg_qsel = value[2:0];
         CSR_MIN: cfg_min = value;
         CSR_MAX: cfg_max = value;
         CSR_BINS: cfg_bins = value[6:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [2:0] q, logic [31:0] lo, logic [31:0] hi,
                             logic [6:0] n);
      wait_idle();
      write_csr(CSR_QSEL, {29'd0, q});
      write_csr(CSR_MIN, lo);
      write_csr(CSR_MAX, hi);
      write_csr(CSR_BINS, {25'd0, n});
   endtask

   // result monitor
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid) begin
         bins_checked++;
         if (expected_bins.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transaction: %p", rsp_data);
         end else begin
            exp_r = expected_bins.pop_front();
            if (rsp_data !== exp_r) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"bin mismatch: expected idx %0d start %0d prob %0d last %0d,",
                            " got idx %0d start %0d prob %0d last %0d"},
                           exp_r.bin_index, exp_r.bin_start, exp_r.probability,
                           exp_r.last_bin, rsp_data.bin_index, rsp_data.bin_start,
                           rsp_data.probability, rsp_data.last_bin);
            end
         end
      end
   end

   task automatic test_reset_defaults();
      // pt with the power-on range of 0..25600
      send_event(32'sd3 << 8, 32'sd4 << 8, 32'sd0, 32'sd0);
      send_event(32'sd0, 32'sd0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_event(32'sd25599, 32'sd0, 32'sd0, 32'sd0);
      send_event(32'sd25600, 32'sd0, 32'sd0, 32'sd0);
      send_readout();
   endtask

   task automatic test_components();
      set_config(QSEL_PX, -32'sd1000, 32'sd1000, 7'd8);
      send_event(-32'sd1000, 32'sd5, 32'sd5, 32'sd5);
      send_event(32'sd999, 32'sd5, 32'sd5, 32'sd5);
      set_config(QSEL_PY, -32'sd1000, 32'sd1000, 7'd8);
      send_event(32'sd5, -32'sd1, 32'sd5, 32'sd5);
      set_config(QSEL_PZ, -32'sd1000, 32'sd1000, 7'd8);
      send_event(32'sd5, 32'sd5, 32'sd500, 32'sd5);
      set_config(QSEL_EN, -32'sd1000, 32'sd1000, 7'd8);
      send_event(32'sd5, 32'sd5, 32'sd5, 32'sd0);
      send_readout();
   endtask

   task automatic test_mass();
      set_config(QSEL_MASS, 32'sd0, 32'sd4096, 7'd16);
      send_event(32'sd300, 32'sd400, 32'sd0, 32'sd1300);
      // spacelike vector is dropped
      send_event(32'sd1000, 32'sd0, 32'sd0, 32'sd10);
      send_event(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_readout();
      // selector codes past mass count nothing
      set_config(3'd7, 32'sd0, 32'sd4096, 7'd4);
      send_event(32'sd10, 32'sd10, 32'sd10, 32'sd10);
      send_readout();
   endtask

   task automatic test_range_edges();
      set_config(QSEL_PX, 32'h8000_0000, 32'h7FFF_FFFF, 7'd0);
      send_event(32'h8000_0000, 32'sd0, 32'sd0, 32'sd0);
      send_readout();
      set_config(QSEL_PX, 32'sd500, 32'sd500, 7'd127);
      send_event(32'sd500, 32'sd0, 32'sd0, 32'sd0);
      send_readout();
   endtask

   task automatic test_bin_count_change();
      set_config(QSEL_PX, 32'sd0, 32'sd6400, 7'd64);
      send_event(32'sd6300, 32'sd0, 32'sd0, 32'sd0);
      send_event(32'sd10, 32'sd0, 32'sd0, 32'sd0);
      // shrinking the bin count keeps the upper bins in the total
      set_config(QSEL_PX, 32'sd0, 32'sd6400, 7'd2);
      send_readout();
   endtask

   function automatic logic [31:0] rand_signed(longint bound);
      longint r;
      r = longint'($urandom_range(0, 32'(2 * bound))) - bound;
      return 32'(r);
   endfunction

   task automatic test_random();
      longint span;
      longint lo;
      longint hi;
      logic [31:0] x, y, z, e;
      logic [2:0] q;
      for (int ph = 0; ph < 8; ph++) begin
         pace_off = (ph == 3);
         q = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                         : 3'($urandom_range(0, 5));
         case ($urandom_range(0, 4))
            0: begin lo = 0; hi = 25600; end
            1: begin lo = -12800; hi = 12800; end
            2: begin lo = -2147483648; hi = 2147483647; end
            3: begin lo = $urandom_range(0, 4000); hi = lo - $urandom_range(0, 50); end
            default: begin
               lo = -longint'($urandom_range(0, 1 << 20));
               hi = $urandom_range(1, 1 << 20);
            end
         endcase
         set_config(q, 32'(lo), 32'(hi), 7'($urandom_range(0, 9) == 0 ?
                    $urandom_range(0, 127) : $urandom_range(1, 64)));
         span = (hi > 0) ? hi : 1000;
         if (span > (1 << 28)) span = 1 << 28;
         for (int i = 0; i < 16; i++) begin
            case ($urandom_range(0, 9))
               0: begin x = $urandom; y = $urandom; z = $urandom; e = $urandom; end
               1, 2: begin
                  x = rand_signed(span); y = rand_signed(span);
                  z = rand_signed(span); e = rand_signed(span);
               end
               default: begin
                  x = rand_signed(span / 2); y = rand_signed(span / 2);
                  z = rand_signed(span / 2);
                  e = (q == QSEL_MASS) ? 32'(span + $urandom_range(0, 32'(span)))
                                       : rand_signed(span);
               end
            endcase
            send_event(x, y, z, e);
         end
         send_readout();
      end
      pace_off = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_qsel = QSEL_PT;
      cfg_min = 32'sd0;
      cfg_max = 32'sd25600;
      cfg_bins = 7'd64;
      clear_histogram();
      mismatches = 0;
      events_sent = 0;
      readouts_sent = 0;
      bins_checked = 0;
      pace_off = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      test_reset_defaults();
      test_components();
      test_mass();
      test_range_edges();
      test_bin_count_change();
      test_random();

      wait_idle();
      $display("histogram run: %0d events binned over %0d read-outs, %0d bin reports checked",
               events_sent, readouts_sent, bins_checked);
      $display("settings covered all selectors, empty and full-width ranges, 1..64 bins");
      if (mismatches == 0 && expected_bins.size() == 0) begin
         $display("** four_vector_histogram_unit: PASSED **");
      end else begin
         $display("** four_vector_histogram_unit: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire
